// File: hw/rtl/cubic_bezier_easing_unit_defines.svh
// Assertion shorthands shared by the RTL.
`ifndef CUBIC_BEZIER_EASING_UNIT_DEFINES_SVH
`define CUBIC_BEZIER_EASING_UNIT_DEFINES_SVH

// Check that a property holds at every clock edge outside reset.
`define CBE_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never occurs outside reset.
`define CBE_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: hw/rtl/cbe_pkg.sv
package cbe_pkg;

  localparam int FRAC_BITS = 16;
  localparam logic [16:0] ONE = 17'd65536;
  localparam logic [16:0] TOL = 17'd7;

  // Control point constants, Q16 rounded to nearest
  localparam logic [16:0] C_0P25 = 17'd16384;
  localparam logic [16:0] C_0P42 = 17'd27525;
  localparam logic [16:0] C_0P58 = 17'd38011;
  localparam logic signed [18:0] C_0P10 = 19'sd6554;
  localparam logic signed [18:0] C_ONE_S = 19'sd65536;

  localparam logic [2:0] MODE_LINEAR      = 3'd0;
  localparam logic [2:0] MODE_EASE        = 3'd1;
  localparam logic [2:0] MODE_EASE_IN     = 3'd2;
  localparam logic [2:0] MODE_EASE_OUT    = 3'd3;
  localparam logic [2:0] MODE_EASE_IN_OUT = 3'd4;
  localparam logic [2:0] MODE_CUSTOM      = 3'd5;

  localparam logic [2:0] REG_CURVE_MODE = 3'd0;
  localparam logic [2:0] REG_CTRL_X1    = 3'd1;
  localparam logic [2:0] REG_CTRL_Y1    = 3'd2;
  localparam logic [2:0] REG_CTRL_X2    = 3'd3;
  localparam logic [2:0] REG_CTRL_Y2    = 3'd4;

  // Micro-program steps of the shared multiplier
  localparam logic [3:0] STEP_UU    = 4'd0;
  localparam logic [3:0] STEP_UT    = 4'd1;
  localparam logic [3:0] STEP_TT    = 4'd2;
  localparam logic [3:0] STEP_UUT   = 4'd3;
  localparam logic [3:0] STEP_UTT   = 4'd4;
  localparam logic [3:0] STEP_TTT   = 4'd5;
  localparam logic [3:0] STEP_PA    = 4'd6;
  localparam logic [3:0] STEP_PB    = 4'd7;
  localparam logic [3:0] STEP_SA    = 4'd8;
  localparam logic [3:0] STEP_SBA   = 4'd9;
  localparam logic [3:0] STEP_SB    = 4'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_NEWTON,
    PH_BISECT,
    PH_FINAL
  } phase_t;

endpackage

// File: hw/rtl/cubic_bezier_easing_unit.sv
// Flow: a request is accepted while idle; curve modes then run curve evaluations, slopes and
//   Newton divides, with a bisection fallback; linear modes give the result the cycle after acceptance.
//   The work is carried by the one shared multiplier and the 1-bit-per-cycle divider.
//   One request at a time: no new request is taken until the result has been handed out.
// Reset (synchronous, rst high): idle, no result pending, registers at their defaults.
`include "cubic_bezier_easing_unit_defines.svh"

module cubic_bezier_easing_unit
  import cbe_pkg::*;
#(
  parameter int NEWTON_STEPS = 8,
  parameter int BISECT_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [17:0] progress,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [18:0] eased,
  input  logic               cfg_en,
  input  logic [2:0]         cfg_addr,
  input  logic [18:0]        cfg_data
);

  localparam int MAX_STEPS = (NEWTON_STEPS > BISECT_STEPS) ? NEWTON_STEPS : BISECT_STEPS;
  localparam int IW = $clog2(MAX_STEPS + 1);
  // Divider: dividend is |err| << 16, divisor is |slope|
  localparam int NW = 36;
  localparam int DW = 22;
  localparam int CW = $clog2(NW + 1);

  // Configuration registers
  logic [2:0]         curve_mode;
  logic [16:0]        ctrl_x1;
  logic signed [18:0] ctrl_y1;
  logic [16:0]        ctrl_x2;
  logic signed [18:0] ctrl_y2;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_mode <= MODE_LINEAR;
      ctrl_x1    <= '0;
      ctrl_y1    <= '0;
      ctrl_x2    <= ONE;
      ctrl_y2    <= C_ONE_S;
    end else if (cfg_en) begin
      unique case (cfg_addr)
        REG_CURVE_MODE: curve_mode <= cfg_data[2:0];
        REG_CTRL_X1:    ctrl_x1    <= cfg_data[16:0];
        REG_CTRL_Y1:    ctrl_y1    <= $signed(cfg_data);
        REG_CTRL_X2:    ctrl_x2    <= cfg_data[16:0];
        REG_CTRL_Y2:    ctrl_y2    <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  state_t state, state_next;
  phase_t phase;
  logic [3:0]  step;
  logic [IW-1:0] iter;

  // Working registers of the solver
  logic [16:0] x, t, lo, hi;
  logic [16:0] cx1, cx2;
  logic signed [18:0] cy1, cy2;
  logic signed [23:0] uu, ut, tt, uut, utt, acc;
  logic signed [23:0] err;

  // Divider registers
  logic [NW-1:0] quot;
  logic [DW:0]   rem;
  logic [DW-1:0] dvs;
  logic          qneg;
  logic [CW-1:0] dcnt;

  // Clamp progress to [0, ONE]
  logic [16:0] p_clamped;
  always_comb begin
    if (progress < 0)
      p_clamped = '0;
    else if (progress > $signed({1'b0, ONE}))
      p_clamped = ONE;
    else
      p_clamped = progress[16:0];
  end

  // Shared multiplier: operand select, multiply, round half up to Q16
  logic [17:0]        u;
  logic signed [19:0] op_a, op_b, coef_a, coef_b;
  logic signed [39:0] prod;
  logic signed [39:0] prod_rnd;
  logic signed [23:0] mres, mres3, mres6;

  assign u = 18'(ONE) - {1'b0, t};
  assign coef_a = (phase == PH_FINAL) ? 20'(cy1) : $signed({3'b0, cx1});
  assign coef_b = (phase == PH_FINAL) ? 20'(cy2) : $signed({3'b0, cx2});

  always_comb begin
    unique case (step)
      STEP_UU:  begin op_a = $signed({2'b0, u}); op_b = $signed({2'b0, u}); end
      STEP_UT:  begin op_a = $signed({2'b0, u}); op_b = $signed({3'b0, t}); end
      STEP_TT:  begin op_a = $signed({3'b0, t}); op_b = $signed({3'b0, t}); end
      STEP_UUT: begin op_a = 20'(uu);            op_b = $signed({3'b0, t}); end
      STEP_UTT: begin op_a = 20'(ut);            op_b = $signed({3'b0, t}); end
      STEP_TTT: begin op_a = 20'(tt);            op_b = $signed({3'b0, t}); end
      STEP_PA:  begin op_a = coef_a;             op_b = 20'(uut); end
      STEP_PB:  begin op_a = coef_b;             op_b = 20'(utt); end
      STEP_SA:  begin op_a = 20'(uu);            op_b = $signed({3'b0, cx1}); end
      STEP_SBA: begin
        op_a = 20'(ut);
        op_b = $signed({3'b0, cx2}) - $signed({3'b0, cx1});
      end
      STEP_SB:  begin
        op_a = 20'(tt);
        op_b = $signed({3'b0, ONE}) - $signed({3'b0, cx2});
      end
      default:  begin op_a = '0; op_b = '0; end
    endcase
  end

  assign prod     = op_a * op_b;
  assign prod_rnd = prod + 40'sd32768;
  assign mres     = prod_rnd[39:16];
  assign mres3    = mres + (mres <<< 1);
  assign mres6    = mres3 <<< 1;

  // Results at the end of a curve evaluation or of a slope
  logic signed [23:0] bez_val, slope_val, bez_err, err_abs;
  logic               match;
  assign bez_val   = acc + mres3;
  assign slope_val = acc + mres3;
  assign bez_err   = bez_val - $signed({7'b0, x});
  assign err_abs   = (bez_err < 0) ? -bez_err : bez_err;
  assign match     = err_abs <= $signed({7'b0, TOL});

  // Bisection bracket update
  logic [16:0] lo_new, hi_new;
  logic [17:0] mid_sum;
  assign lo_new  = (bez_err > 0) ? lo : t;
  assign hi_new  = (bez_err > 0) ? t : hi;
  assign mid_sum = {1'b0, lo_new} + {1'b0, hi_new};

  // Divider step and Newton update
  logic [DW:0]   rem_sh;
  logic          rem_ge;
  logic [NW-1:0] quot_fin;
  logic signed [NW+1:0] t_new_w;
  logic [16:0]   t_newton;
  assign rem_sh   = {rem[DW-1:0], quot[NW-1]};
  assign rem_ge   = rem_sh >= {1'b0, dvs};
  assign quot_fin = {quot[NW-2:0], rem_ge};
  always_comb begin
    if (qneg)
      t_new_w = $signed({{(NW-16){1'b0}}, t}) + $signed({2'b0, quot_fin});
    else
      t_new_w = $signed({{(NW-16){1'b0}}, t}) - $signed({2'b0, quot_fin});
    if (t_new_w < 0)
      t_newton = '0;
    else if (t_new_w > $signed({{(NW-16){1'b0}}, ONE}))
      t_newton = ONE;
    else
      t_newton = t_new_w[16:0];
  end

  // Output saturation
  logic signed [18:0] sat_val;
  always_comb begin
    if (bez_val > 24'sd262143)
      sat_val = 19'sd262143;
    else if (bez_val < -24'sd262144)
      sat_val = -19'sd262144;
    else
      sat_val = bez_val[18:0];
  end

  logic is_curve;
  assign is_curve = (curve_mode == MODE_EASE) || (curve_mode == MODE_EASE_IN) ||
                    (curve_mode == MODE_EASE_OUT) || (curve_mode == MODE_EASE_IN_OUT) ||
                    (curve_mode == MODE_CUSTOM);

  logic iter_last_newton, iter_last_bisect;
  assign iter_last_newton = iter == IW'(NEWTON_STEPS - 1);
  assign iter_last_bisect = iter == IW'(BISECT_STEPS - 1);

  // State register
  always_ff @(posedge clk) begin
    if (rst)
      state <= ST_IDLE;
    else
      state <= state_next;
  end

  // Next state and handshake outputs
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid)
          state_next = is_curve ? ST_CALC : ST_OUT;
      end
      ST_CALC: begin
        if (step == STEP_PB && phase == PH_FINAL)
          state_next = ST_OUT;
        else if (step == STEP_SB && slope_val != 0)
          state_next = ST_DIV;
      end
      ST_DIV: begin
        if (dcnt == CW'(NW - 1))
          state_next = ST_CALC;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready)
          state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Solver datapath and sequencer counters
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_NEWTON;
      step  <= STEP_UU;
      iter  <= '0;
      dcnt  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            // Latch the curve and start Newton from t = x
            x     <= p_clamped;
            t     <= p_clamped;
            lo    <= '0;
            hi    <= ONE;
            eased <= $signed({2'b0, p_clamped});
            phase <= PH_NEWTON;
            step  <= STEP_UU;
            iter  <= '0;
            unique case (curve_mode)
              MODE_EASE: begin
                cx1 <= C_0P25; cy1 <= C_0P10; cx2 <= C_0P25; cy2 <= C_ONE_S;
              end
              MODE_EASE_IN: begin
                cx1 <= C_0P42; cy1 <= '0; cx2 <= ONE; cy2 <= C_ONE_S;
              end
              MODE_EASE_OUT: begin
                cx1 <= '0; cy1 <= '0; cx2 <= C_0P58; cy2 <= C_ONE_S;
              end
              MODE_EASE_IN_OUT: begin
                cx1 <= C_0P42; cy1 <= '0; cx2 <= C_0P58; cy2 <= C_ONE_S;
              end
              default: begin
                // Custom; saturate control x to ONE
                cx1 <= (ctrl_x1 > ONE) ? ONE : ctrl_x1;
                cx2 <= (ctrl_x2 > ONE) ? ONE : ctrl_x2;
                cy1 <= ctrl_y1;
                cy2 <= ctrl_y2;
              end
            endcase
          end
        end
        ST_CALC: begin
          step <= step + 4'd1;
          unique case (step)
            STEP_UU:  uu  <= mres;
            STEP_UT:  ut  <= mres;
            STEP_TT:  tt  <= mres;
            STEP_UUT: uut <= mres;
            STEP_UTT: utt <= mres;
            STEP_TTT: acc <= mres;
            STEP_PA:  acc <= acc + mres3;
            STEP_SA:  acc <= mres3;
            STEP_SBA: acc <= acc + mres6;
            STEP_PB: begin
              step <= STEP_UU;
              priority case (phase)
                PH_FINAL: eased <= sat_val;
                PH_NEWTON: begin
                  if (match) begin
                    phase <= PH_FINAL;
                  end else begin
                    err  <= bez_err;
                    step <= STEP_SA;
                  end
                end
                default: begin
                  // Bisection: stop on a match, else halve the bracket and stop after the last step
                  if (match) begin
                    phase <= PH_FINAL;
                  end else begin
                    lo   <= lo_new;
                    hi   <= hi_new;
                    t    <= mid_sum[17:1];
                    iter <= iter + IW'(1);
                    if (iter_last_bisect)
                      phase <= PH_FINAL;
                  end
                end
              endcase
            end
            STEP_SB: begin
              step <= STEP_UU;
              if (slope_val == 0) begin
                // Flat slope: drop Newton and restart with bisection
                phase <= PH_BISECT;
                t     <= x;
                lo    <= '0;
                hi    <= ONE;
                iter  <= '0;
              end else begin
                quot <= NW'((err < 0) ? -err : err) << FRAC_BITS;
                rem  <= '0;
                dvs  <= DW'((slope_val < 0) ? -slope_val : slope_val);
                qneg <= (err < 0) != (slope_val < 0);
                dcnt <= '0;
              end
            end
            default: step <= STEP_UU;
          endcase
        end
        ST_DIV: begin
          // Restoring division, one quotient bit per cycle
          quot <= quot_fin;
          rem  <= rem_ge ? (rem_sh - {1'b0, dvs}) : rem_sh;
          dcnt <= dcnt + CW'(1);
          if (dcnt == CW'(NW - 1)) begin
            iter <= iter + IW'(1);
            if (iter_last_newton) begin
              phase <= PH_BISECT;
              t     <= x;
              lo    <= '0;
              hi    <= ONE;
              iter  <= '0;
            end else begin
              t <= t_newton;
            end
          end
        end
        ST_OUT: ;
        default: ;
      endcase
    end
  end

  `CBE_CHECK(a_t_in_range, (state != ST_IDLE) |-> t <= ONE, "curve parameter above one")
  `CBE_NEVER(a_ready_and_valid, in_ready && out_valid, "accepting while result pending")
  `CBE_CHECK(a_bracket, (state == ST_CALC && phase == PH_BISECT) |-> lo <= hi, "bad bracket")
  `CBE_CHECK(a_div_entry, $rose(state == ST_DIV) |-> $past(step == STEP_SB), "stray divide")

endmodule

// File: test/cubic_bezier_easing_unit_tb.sv
module cubic_bezier_easing_unit_tb;
  import cbe_pkg::*;

  // Spare mode codes: the block treats them as linear
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;
  localparam longint QONE = 65536;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic signed [17:0] progress;
  logic               out_valid;
  logic               out_ready;
  logic signed [18:0] eased;
  logic               cfg_en;
  logic [2:0]         cfg_addr;
  logic [18:0]        cfg_data;

  cubic_bezier_easing_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .progress(progress),
    .out_valid(out_valid), .out_ready(out_ready), .eased(eased),
    .cfg_en(cfg_en), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Shadow copy of the configuration registers, updated on every write
  logic [2:0]         sh_mode;
  logic [16:0]        sh_x1;
  logic signed [18:0] sh_y1;
  logic [16:0]        sh_x2;
  logic signed [18:0] sh_y2;

  // Expected eased values, oldest first
  logic signed [18:0] eased_q[$];
  int                 errors;
  bit                 calm;      // when set, neither side idles
  bit                 hold_off;  // long receiver hold-off
  int                 stall_left;

  task automatic report(input string what, input logic signed [18:0] got,
                        input logic signed [18:0] want);
    $display("mismatch %s: eased got %0d want %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // Q16 product rounded half up (arithmetic shift floors)
  function automatic longint qmul(input longint a, input longint b);
    return (a * b + 32768) >>> 16;
  endfunction

  function automatic longint curve_at(input longint a, input longint b, input longint t);
    longint u;
    u = QONE - t;
    return 3 * qmul(a, qmul(qmul(u, u), t)) + 3 * qmul(b, qmul(qmul(u, t), t))
         + qmul(qmul(t, t), t);
  endfunction

  function automatic longint curve_slope(input longint a, input longint b, input longint t);
    longint u;
    u = QONE - t;
    return 3 * qmul(qmul(u, u), a) + 6 * qmul(qmul(u, t), b - a)
         + 3 * qmul(qmul(t, t), QONE - b);
  endfunction

  function automatic longint abs_l(input longint v);
    return v < 0 ? -v : v;
  endfunction

  // Solve x(t) = x by Newton, fall back to bisection, return y(t)
  function automatic longint ease_solve(input longint x, input longint x1, input longint y1,
                                        input longint x2, input longint y2);
    longint t, lo, hi, err, d, v;
    t = x; lo = 0; hi = QONE;
    for (int i = 0; i < 8; i++) begin
      err = curve_at(x1, x2, t) - x;
      if (abs_l(err) <= longint'(TOL)) return curve_at(y1, y2, t);
      d = curve_slope(x1, x2, t);
      if (d == 0) break;
      t = t - (err * QONE) / d;
      if (t < 0) t = 0;
      if (t > QONE) t = QONE;
    end
    t = x;
    for (int i = 0; i < 24; i++) begin
      v = curve_at(x1, x2, t);
      if (abs_l(v - x) <= longint'(TOL)) break;
      if (v > x) hi = t;
      else lo = t;
      t = (lo + hi) / 2;
    end
    return curve_at(y1, y2, t);
  endfunction

  function automatic logic signed [18:0] predict_eased(input logic signed [17:0] p);
    longint x, y, cx1, cx2;
    x = p;
    if (x < 0) x = 0;
    if (x > QONE) x = QONE;
    case (sh_mode)
      MODE_EASE:        y = ease_solve(x, 16384, longint'(C_0P10), 16384, QONE);
      MODE_EASE_IN:     y = ease_solve(x, longint'(C_0P42), 0, QONE, QONE);
      MODE_EASE_OUT:    y = ease_solve(x, 0, 0, longint'(C_0P58), QONE);
      MODE_EASE_IN_OUT: y = ease_solve(x, longint'(C_0P42), 0, longint'(C_0P58), QONE);
      MODE_CUSTOM: begin
        cx1 = sh_x1 > 65536 ? QONE : longint'(sh_x1);
        cx2 = sh_x2 > 65536 ? QONE : longint'(sh_x2);
        y = ease_solve(x, cx1, longint'(sh_y1), cx2, longint'(sh_y2));
      end
      default: y = x;
    endcase
    if (y > 262143) y = 262143;
    if (y < -262144) y = -262144;
    return y[18:0];
  endfunction

  // Hold until every expected result has come back
  task automatic wait_drained();
    while (eased_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all five registers back to back; the block must be idle
  task automatic set_curve(input logic [2:0] mode, input logic [16:0] x1,
                           input logic [18:0] y1, input logic [16:0] x2,
                           input logic [18:0] y2);
    logic [18:0] vals[5];
    logic [2:0]  regs[5];
    vals = '{19'(mode), 19'(x1), y1, 19'(x2), y2};
    regs = '{REG_CURVE_MODE, REG_CTRL_X1, REG_CTRL_Y1, REG_CTRL_X2, REG_CTRL_Y2};
    wait_drained();
    for (int i = 0; i < 5; i++) begin
      cfg_en   <= 1'b1;
      cfg_addr <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_en <= 1'b0;
    sh_mode = mode; sh_x1 = x1; sh_y1 = y1; sh_x2 = x2; sh_y2 = y2;
  endtask

  // Offer one request, hold it until accepted, then maybe idle
  task automatic send_progress(input logic signed [17:0] p);
    int gap;
    in_valid <= 1'b1;
    progress <= p;
    do @(posedge clk); while (!in_ready);
    eased_q.push_back(predict_eased(p));
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly in range, with some out-of-range and full-width values
  function automatic logic signed [17:0] rand_progress();
    case ($urandom_range(0, 9))
      0:       return 18'($urandom_range(0, 262143));
      1:       return 18'(65536 + $urandom_range(0, 3));
      2:       return 18'($urandom_range(0, 8));
      default: return 18'($urandom_range(0, 65536));
    endcase
  endfunction

  // Receiver: random stall bursts, or a long hold-off when asked
  always @(posedge clk) begin
    if (rst || hold_off) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (eased_q.size() == 0) report("unexpected result", eased, 'x);
      else begin
        if (eased !== eased_q[0]) report("value", eased, eased_q[0]);
        void'(eased_q.pop_front());
      end
    end
  end

  // Linear after reset: clamp extremes and the values on either side of zero and one
  task automatic test_linear_clamp();
    logic signed [17:0] edges[8];
    edges = '{-18'sd131072, -18'sd1, 18'sd0, 18'sd1, 18'sd65535, 18'sd65536,
              18'sd65537, 18'sd131071};
    foreach (edges[i]) send_progress(edges[i]);
    end_burst();
  endtask

  // Every mode, spare codes included, at the ends and the middle
  task automatic test_all_modes();
    logic [2:0] modes[8];
    modes = '{MODE_LINEAR, MODE_EASE, MODE_EASE_IN, MODE_EASE_OUT, MODE_EASE_IN_OUT,
              MODE_CUSTOM, MODE_SPARE6, MODE_SPARE7};
    foreach (modes[i]) begin
      set_curve(modes[i], 17'd16384, 19'd100000, 17'd50000, 19'h40000);
      send_progress(18'sd0);
      send_progress(18'sd32768);
      send_progress(18'sd65536);
      end_burst();
    end
  endtask

  // Custom curves at the register limits: flat slopes, x above one, y extremes
  task automatic test_custom_extremes();
    set_curve(MODE_CUSTOM, 17'd0, 19'h3FFFF, 17'd0, 19'h40000);
    send_progress(18'sd20000); send_progress(18'sd65536);
    end_burst();
    set_curve(MODE_CUSTOM, 17'h1FFFF, 19'h40000, 17'h1FFFF, 19'h3FFFF);
    send_progress(18'sd1); send_progress(18'sd45000);
    end_burst();
    set_curve(MODE_CUSTOM, 17'd65536, 19'd0, 17'd0, 19'd65536);
    send_progress(18'sd32768); send_progress(18'sd3);
    end_burst();
  endtask

  // Random phases of curve settings with random progress
  task automatic test_random_curves(input int phases, input int per_phase);
    logic [18:0] y1, y2;
    for (int ph = 0; ph < phases; ph++) begin
      y1 = ($urandom_range(0, 3) == 0) ? 19'($urandom) : 19'($urandom_range(0, 131072) - 32768);
      y2 = ($urandom_range(0, 3) == 0) ? 19'($urandom) : 19'($urandom_range(0, 131072) - 32768);
      set_curve(3'($urandom_range(0, 7)),
                ($urandom_range(0, 5) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536)),
                y1,
                ($urandom_range(0, 5) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536)),
                y2);
      repeat (per_phase) send_progress(rand_progress());
      end_burst();
    end
  endtask

  // Hold the receiver off long enough to stall the input, then drain and send another burst
  task automatic test_backpressure();
    set_curve(MODE_EASE_IN_OUT, 17'd0, 19'd0, 17'd65536, 19'd65536);
    hold_off <= 1'b1;
    fork
      begin
        repeat (2000) @(posedge clk);
        hold_off <= 1'b0;
      end
      repeat (6) send_progress(rand_progress());
    join
    end_burst();
    wait_drained();
    repeat (10) send_progress(rand_progress());
    end_burst();
  endtask

  initial begin
    rst = 1'b1; in_valid = 1'b0; progress = '0;
    cfg_en = 1'b0; cfg_addr = '0; cfg_data = '0;
    out_ready = 1'b0; hold_off = 1'b0; stall_left = 0; calm = 1'b0; errors = 0;
    sh_mode = MODE_LINEAR; sh_x1 = 17'd0; sh_y1 = 19'sd0;
    sh_x2 = 17'd65536; sh_y2 = 19'sd65536;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_linear_clamp();
    test_all_modes();
    test_custom_extremes();
    test_backpressure();
    test_random_curves(30, 22);
    // last stretch with neither side idling
    calm = 1'b1;
    test_random_curves(6, 20);

    wait_drained();
    repeat (700) @(posedge clk);
    if (errors == 0 && eased_q.size() == 0) begin
      $display("cubic_bezier_easing_unit_tb passed");
    end else begin
      if (eased_q.size() != 0) report("missing results", 'x, 'x);
      $display("cubic_bezier_easing_unit_tb failed");
    end
    $finish;
  end

  initial begin
    #100000000;
    $display("cubic_bezier_easing_unit_tb failed");
    $finish;
  end

endmodule
